// ----- src/pcbc_pkg.sv -----
// Package: types, code constants and bit-permutation functions for the (12,8) block codec
package pcbc_pkg;

    localparam int unsigned C_LANES = 4;
    localparam int unsigned C_BYTES = 6;

    typedef logic [C_BYTES-1:0][7:0] t_block;

    typedef enum logic {
        OP_ENCODE = 1'b0,
        OP_DECODE = 1'b1
    } t_op;

    typedef struct packed {
        logic [3:0] nib;
        logic [7:0] dec;
    } t_lane_res;

    localparam logic [3:0][7:0]  C_GEN = {8'hE8, 8'h0F, 8'hB3, 8'hD5};
    localparam logic [3:0][11:0] C_CHK = {12'h1D5, 12'h2B3, 12'h40F, 12'h8E8};
    localparam logic [15:0][11:0] C_COSET = {
        12'h801, 12'h001, 12'h080, 12'h010, 12'h084, 12'h004, 12'h040, 12'h100,
        12'h208, 12'h002, 12'h020, 12'h200, 12'h008, 12'h400, 12'h800, 12'h000
    };

    // coded bit 6b+a takes plain byte a bit b
    function automatic t_block f_spread(input t_block src);
        logic [8*C_BYTES-1:0] dst;
        dst = '0;
        for (int b = 0; b < 8; b++) begin
            for (int a = 0; a < C_BYTES; a++) begin
                dst[C_BYTES*b+a] = src[a][b];
            end
        end
        return t_block'(dst);
    endfunction

    function automatic t_block f_gather(input t_block src);
        logic [8*C_BYTES-1:0] flat;
        t_block dst;
        flat = src;
        for (int a = 0; a < C_BYTES; a++) begin
            for (int b = 0; b < 8; b++) begin
                dst[a][b] = flat[C_BYTES*b+a];
            end
        end
        return dst;
    endfunction

endpackage

// ----- src/pcbc_in_if.sv -----
// Interface: input channel carrying one block word
interface pcbc_in_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [7:0] in_byte0;
    logic [7:0] in_byte1;
    logic [7:0] in_byte2;
    logic [7:0] in_byte3;
    logic [7:0] in_byte4;
    logic [7:0] in_byte5;

    modport source (
        output valid, operation, in_byte0, in_byte1, in_byte2, in_byte3, in_byte4, in_byte5,
        input  ready
    );
    modport sink (
        input  valid, operation, in_byte0, in_byte1, in_byte2, in_byte3, in_byte4, in_byte5,
        output ready
    );
endinterface

// ----- src/pcbc_out_if.sv -----
// Interface: output channel carrying one result word
interface pcbc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte0;
    logic [7:0] out_byte1;
    logic [7:0] out_byte2;
    logic [7:0] out_byte3;
    logic [7:0] out_byte4;
    logic [7:0] out_byte5;

    modport source (
        output valid, out_byte0, out_byte1, out_byte2, out_byte3, out_byte4, out_byte5,
        input  ready
    );
    modport sink (
        input  valid, out_byte0, out_byte1, out_byte2, out_byte3, out_byte4, out_byte5,
        output ready
    );
endinterface

// ----- src/pcbc_lane.sv -----
// Lane: parity nibble of one data byte and single-error fix of one 12-bit code word
module pcbc_lane import pcbc_pkg::*; (
    input  logic [7:0] i_byte,
    input  logic [3:0] i_nib,
    output t_lane_res  o_res
);

    logic [11:0] w_word;
    logic [3:0]  w_syn;
    logic [11:0] w_fixed;

    assign w_word = {i_nib, i_byte};

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            o_res.nib[i] = ^(i_byte & C_GEN[i]);
            w_syn[i]     = ^(w_word & C_CHK[i]);
        end
        w_fixed   = w_word ^ C_COSET[w_syn];
        o_res.dec = w_fixed[7:0];
    end

endmodule

// ----- src/pcbc_merge.sv -----
// Merge: assemble the coded block or the decoded bytes from the lane results
module pcbc_merge import pcbc_pkg::*; (
    input  t_op                      i_op,
    input  logic                     i_ilv,
    input  logic [C_LANES-1:0][7:0]  i_data,
    input  t_lane_res [C_LANES-1:0]  i_lane,
    output t_block                   o_block
);

    t_block w_enc;

    always_comb begin
        w_enc[0] = i_data[0];
        w_enc[1] = i_data[1];
        w_enc[2] = {i_lane[1].nib, i_lane[0].nib};
        w_enc[3] = i_data[2];
        w_enc[4] = i_data[3];
        w_enc[5] = {i_lane[3].nib, i_lane[2].nib};
    end

    always_comb begin
        unique case (i_op)
            OP_ENCODE: begin
                o_block = i_ilv ? f_spread(w_enc) : w_enc;
            end
            OP_DECODE: begin
                o_block    = '0;
                o_block[0] = i_lane[0].dec;
                o_block[1] = i_lane[1].dec;
                o_block[2] = i_lane[2].dec;
                o_block[3] = i_lane[3].dec;
            end
            default: begin
                o_block = '0;
            end
        endcase
    end

endmodule

// ----- src/parity_12_8_block_codec_core.sv -----
// Top level: (12,8) block codec, four parallel lanes, registered output word
// An accepted input word is registered and shows as a valid output word in the next cycle.
// Throughput: one word per cycle; the single output register sets the rate and
// the input stays ready while the held word is taken in the same cycle.
// Reset (synchronous, active low): output empty, interleave enable set to 1.
module parity_12_8_block_codec_core import pcbc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    pcbc_in_if.sink     i_in,
    pcbc_out_if.source  o_out
);

    logic      r_ilv;
    logic      r_vld;
    t_block    r_out;
    t_block    n_out;

    logic      w_accept;
    t_op       w_op;
    t_block    w_raw;
    t_block    w_t;
    logic [C_LANES-1:0][7:0] w_lane_byte;
    logic [C_LANES-1:0][3:0] w_lane_nib;
    t_lane_res [C_LANES-1:0] w_lane;

    assign i_in.ready = !r_vld || o_out.ready;
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_op       = t_op'(i_in.operation);

    assign w_raw = {i_in.in_byte5, i_in.in_byte4, i_in.in_byte3,
                    i_in.in_byte2, i_in.in_byte1, i_in.in_byte0};
    assign w_t   = (w_op == OP_DECODE && r_ilv) ? f_gather(w_raw) : w_raw;

    always_comb begin
        unique case (w_op)
            OP_DECODE: begin
                w_lane_byte = {w_t[4], w_t[3], w_t[1], w_t[0]};
            end
            default: begin
                w_lane_byte = {w_raw[3], w_raw[2], w_raw[1], w_raw[0]};
            end
        endcase
        w_lane_nib = {w_t[5][7:4], w_t[5][3:0], w_t[2][7:4], w_t[2][3:0]};
    end

    for (genvar g = 0; g < C_LANES; g++) begin : g_lane
        pcbc_lane u_lane (
            .i_byte (w_lane_byte[g]),
            .i_nib  (w_lane_nib[g]),
            .o_res  (w_lane[g])
        );
    end

    pcbc_merge u_merge (
        .i_op    (w_op),
        .i_ilv   (r_ilv),
        .i_data  ({w_raw[3], w_raw[2], w_raw[1], w_raw[0]}),
        .i_lane  (w_lane),
        .o_block (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ilv <= 1'b1;
            r_vld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_ilv <= i_cfg_wdata;
            end
            if (w_accept) begin
                r_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid     = r_vld;
    assign o_out.out_byte0 = r_out[0];
    assign o_out.out_byte1 = r_out[1];
    assign o_out.out_byte2 = r_out[2];
    assign o_out.out_byte3 = r_out[3];
    assign o_out.out_byte4 = r_out[4];
    assign o_out.out_byte5 = r_out[5];

endmodule
